>>> rtl/core/ltt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ltt_pkg;

	localparam int NUM_LAYERS_DEF = 4;
	localparam int SLOTS_DEF      = 1024;

	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;
	localparam int ENTRY_W = 45;
	localparam int KEY_W   = 32;

	// result status codes
	localparam logic [2:0] ST_UPDATED   = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_ERASED    = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

	// datapath commands
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_START    = 4'd1;
	localparam logic [3:0] OP_SCAN     = 4'd2;
	localparam logic [3:0] OP_UPDATE   = 4'd3;
	localparam logic [3:0] OP_ERASE_RD = 4'd4;
	localparam logic [3:0] OP_ERASE_WR = 4'd5;
	localparam logic [3:0] OP_INSERT   = 4'd6;
	localparam logic [3:0] OP_NOTFOUND = 4'd7;
	localparam logic [3:0] OP_FULL     = 4'd8;
	localparam logic [3:0] OP_PUSH     = 4'd9;

	typedef struct packed {
		logic              mode;
		logic [1:0]        layer;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [9:0]        texture_id;
		logic [2:0]        tile_kind;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count_after;
	} rsp_t;

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic in_layer_ok;
		logic mode;
		logic hit;
		logic scan_end;
		logic full;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

>>> rtl/core/ltt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module ltt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ltt_pkg::stat_t stat,
	output ltt_pkg::cmd_t      cmd
);
	import ltt_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_ERD  = 3'd2;
	localparam logic [2:0] S_EWR  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_nx = state_q;
		cmd.op   = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op   = OP_START;
					state_nx = stat.in_layer_ok ? S_SCAN : S_FIN;
				end
			end
			S_SCAN: begin
				if (stat.hit) begin
					if (stat.mode) begin
						cmd.op   = OP_ERASE_RD;
						state_nx = S_ERD;
					end else begin
						cmd.op   = OP_UPDATE;
						state_nx = S_FIN;
					end
				end else if (stat.scan_end) begin
					if (stat.mode)
						cmd.op = OP_NOTFOUND;
					else if (stat.full)
						cmd.op = OP_FULL;
					else
						cmd.op = OP_INSERT;
					state_nx = S_FIN;
				end else begin
					cmd.op = OP_SCAN;
				end
			end
			S_ERD: begin
				cmd.op   = OP_ERASE_RD;
				state_nx = S_EWR;
			end
			S_EWR: begin
				cmd.op   = OP_ERASE_WR;
				state_nx = S_FIN;
			end
			S_FIN: begin
				// hold the result until the output register frees up
				if (stat.out_free) begin
					cmd.op   = OP_PUSH;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

endmodule

`default_nettype wire

>>> rtl/core/ltt_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module ltt_dp #(
	parameter int NUM_LAYERS      = ltt_pkg::NUM_LAYERS_DEF,
	parameter int SLOTS_PER_LAYER = ltt_pkg::SLOTS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ltt_pkg::req_t  req,
	input  wire ltt_pkg::cmd_t  cmd,
	output ltt_pkg::stat_t      stat,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output ltt_pkg::rsp_t       rsp
);
	import ltt_pkg::*;

	localparam int SW    = $clog2(SLOTS_PER_LAYER);
	localparam int CW    = $clog2(SLOTS_PER_LAYER + 1);
	localparam int LIW   = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
	localparam int DEPTH = NUM_LAYERS * (2 ** SW);
	localparam int AW    = $clog2(DEPTH);

	logic [ENTRY_W-1:0] entry_mem [DEPTH];
	logic [CW-1:0]      layer_cnt_q [NUM_LAYERS];

	req_t               req_q;
	logic [LIW-1:0]     lay_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      rd_idx_q;
	logic [SW-1:0]      cmp_idx_s1;
	logic               cmp_vld_s1;
	logic [ENTRY_W-1:0] rd_data_s1;
	rsp_t               res_q;
	rsp_t               out_q;
	logic               out_valid_q;

	logic               in_layer_ok;
	logic [LIW-1:0]     in_lay;
	logic [CW-1:0]      in_cnt;
	logic               issue;
	logic               rd_en;
	logic [SW-1:0]      rd_slot;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [SW-1:0]      wr_slot;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] new_entry;
	logic [CW-1:0]      cnt_dec;
	logic [CW-1:0]      cnt_inc;
	logic               cnt_wr;
	logic [CW-1:0]      cnt_wdata;

	assign in_layer_ok = (32'(req.layer) < 32'(NUM_LAYERS));
	assign in_lay      = LIW'(req.layer);
	assign in_cnt      = in_layer_ok ? layer_cnt_q[in_lay] : '0;

	assign issue     = (rd_idx_q < cnt_q);
	assign cnt_dec   = cnt_q - 1'b1;
	assign cnt_inc   = cnt_q + 1'b1;
	assign new_entry = {req_q.tile_kind, req_q.texture_id, req_q.pos_y, req_q.pos_x};

	assign stat.in_layer_ok = in_layer_ok;
	assign stat.mode        = req_q.mode;
	assign stat.hit         = cmp_vld_s1 &&
	                          (rd_data_s1[KEY_W-1:0] == {req_q.pos_y, req_q.pos_x});
	assign stat.scan_end    = !cmp_vld_s1 && (rd_idx_q == cnt_q);
	assign stat.full        = (32'(cnt_q) >= 32'(SLOTS_PER_LAYER));
	assign stat.out_free    = !out_valid_q || !rsp_stall;

	// read port: scan walks slots in order, erase fetches the last entry
	always_comb begin
		rd_en   = 1'b0;
		rd_slot = rd_idx_q[SW-1:0];
		if (cmd.op == OP_SCAN) begin
			rd_en = issue;
		end else if (cmd.op == OP_ERASE_RD) begin
			rd_en   = 1'b1;
			rd_slot = cnt_dec[SW-1:0];
		end
	end
	assign rd_addr = (AW'(lay_q) << SW) | AW'(rd_slot);

	always_comb begin
		wr_en     = 1'b0;
		wr_slot   = cmp_idx_s1;
		wr_data   = new_entry;
		cnt_wr    = 1'b0;
		cnt_wdata = cnt_q;
		case (cmd.op)
			OP_UPDATE: begin
				wr_en = 1'b1;
			end
			OP_ERASE_WR: begin
				wr_en     = 1'b1;
				wr_data   = rd_data_s1;
				cnt_wr    = 1'b1;
				cnt_wdata = cnt_dec;
			end
			OP_INSERT: begin
				wr_en     = 1'b1;
				wr_slot   = cnt_q[SW-1:0];
				cnt_wr    = 1'b1;
				cnt_wdata = cnt_inc;
			end
			default: begin
			end
		endcase
	end
	assign wr_addr = (AW'(lay_q) << SW) | AW'(wr_slot);

	always_ff @(posedge clk) begin
		if (wr_en)
			entry_mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_s1 <= entry_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LAYERS; i++)
				layer_cnt_q[i] <= '0;
		end else if (cnt_wr) begin
			layer_cnt_q[lay_q] <= cnt_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q    <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_START) begin
				rd_idx_q   <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (cmd.op == OP_SCAN) begin
				cmp_vld_s1 <= issue;
				if (issue)
					rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (cmd.op == OP_PUSH)
				out_valid_q <= 1'b1;
			else if (!rsp_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				req_q <= req;
				lay_q <= in_lay;
				cnt_q <= in_cnt;
				res_q <= '{status: req.mode ? ST_NOT_FOUND : ST_FULL,
				           slot: '0, count_after: '0};
			end
			OP_SCAN: begin
				cmp_idx_s1 <= rd_idx_q[SW-1:0];
			end
			OP_UPDATE: begin
				res_q <= '{status: ST_UPDATED, slot: SLOT_W'(cmp_idx_s1),
				           count_after: COUNT_W'(cnt_q)};
			end
			OP_ERASE_WR: begin
				res_q <= '{status: ST_ERASED, slot: SLOT_W'(cmp_idx_s1),
				           count_after: COUNT_W'(cnt_dec)};
			end
			OP_INSERT: begin
				res_q <= '{status: ST_INSERTED, slot: SLOT_W'(cnt_q),
				           count_after: COUNT_W'(cnt_inc)};
			end
			OP_NOTFOUND: begin
				res_q <= '{status: ST_NOT_FOUND, slot: '0, count_after: COUNT_W'(cnt_q)};
			end
			OP_FULL: begin
				res_q <= '{status: ST_FULL, slot: '0, count_after: COUNT_W'(cnt_q)};
			end
			OP_PUSH: begin
				out_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

`default_nettype wire

>>> rtl/core/layered_keyed_tile_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | beat   | valid     | stall     | direction
// request | req    | req_valid | req_stall | in
// result  | rsp    | rsp_valid | rsp_stall | out
//
// A request scans its layer up to the hit on an update or an erase, and the whole layer on an
// insert, a miss or a full layer; a request to an absent layer skips the scan. The layer is
// scanned one entry per cycle through the single read port of the entry memory.
// Reset clears the layer counts but not the entries; entries need no clearing pass.
// The result sits in an output register, so a stalled result delays only the finish of
// the request after it.

module layered_keyed_tile_table_unit #(
	parameter int NUM_LAYERS      = ltt_pkg::NUM_LAYERS_DEF,
	parameter int SLOTS_PER_LAYER = ltt_pkg::SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ltt_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output ltt_pkg::rsp_t      rsp
);
	import ltt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	ltt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ltt_dp #(
		.NUM_LAYERS      (NUM_LAYERS),
		.SLOTS_PER_LAYER (SLOTS_PER_LAYER)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

>>> verif/layered_keyed_tile_table_unit_test.sv
`timescale 1ns / 1ps

module layered_keyed_tile_table_unit_test;
	import ltt_pkg::*;

	localparam int LAYERS = NUM_LAYERS_DEF;
	localparam int SLOTS = SLOTS_DEF;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int POOL_KEYS = 32;
	localparam int RANDOM_ITEMS = 580;

	localparam logic MODE_PLACE = 1'b0;
	localparam logic MODE_ERASE = 1'b1;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [9:0]  tex;
		logic [2:0]  kind;
	} tile_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// shadow of the layer tables, updated when a request beat is accepted
	tile_t tile_mem [LAYERS][SLOTS];
	int    tile_count [LAYERS];
	rsp_t  pending_results [$];

	int mismatch_count = 0;
	int cycle_count = 0;
	int hold_cycles = 0;
	bit idle_en = 1'b1;

	layered_keyed_tile_table_unit #(
		.NUM_LAYERS(LAYERS),
		.SLOTS_PER_LAYER(SLOTS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_en || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic rsp_t tile_table_apply(req_t r);
		rsp_t res;
		int n;
		int hit;
		res = '0;
		hit = -1;
		if (r.layer >= LAYERS) begin
			res.status = (r.mode == MODE_ERASE) ? ST_NOT_FOUND : ST_FULL;
			return res;
		end
		n = tile_count[r.layer];
		for (int i = 0; i < n; i++)
			if (hit < 0 && tile_mem[r.layer][i].x == r.pos_x && tile_mem[r.layer][i].y == r.pos_y)
				hit = i;
		if (hit >= 0 && r.mode == MODE_ERASE) begin
			// pull the last entry into the vacated slot
			n--;
			tile_mem[r.layer][hit] = tile_mem[r.layer][n];
			tile_count[r.layer] = n;
			res.status = ST_ERASED;
			res.slot = hit[SLOT_W-1:0];
		end else if (hit >= 0) begin
			tile_mem[r.layer][hit] = '{r.pos_x, r.pos_y, r.texture_id, r.tile_kind};
			res.status = ST_UPDATED;
			res.slot = hit[SLOT_W-1:0];
		end else if (r.mode == MODE_ERASE) begin
			res.status = ST_NOT_FOUND;
		end else if (n >= SLOTS) begin
			res.status = ST_FULL;
		end else begin
			tile_mem[r.layer][n] = '{r.pos_x, r.pos_y, r.texture_id, r.tile_kind};
			res.status = ST_INSERTED;
			res.slot = n[SLOT_W-1:0];
			n++;
			tile_count[r.layer] = n;
		end
		res.count_after = n[COUNT_W-1:0];
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input rsp_t want, input rsp_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t %0s: expected status %0d slot %0d count %0d, got status %0d slot %0d count %0d",
				$realtime, what, want.status, want.slot, want.count_after,
				got.status, got.slot, got.count_after);
	endtask

	// called at a rising edge; leaves valid high so a back-to-back beat needs no drop
	task automatic send_req(input req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		pending_results.push_back(tile_table_apply(item));
	endtask

	task automatic send_tile(input logic m, input logic [1:0] l, input logic [15:0] x,
		input logic [15:0] y, input logic [9:0] tex, input logic [2:0] kind);
		req_t item;
		item.mode = m;
		item.layer = l;
		item.pos_x = x;
		item.pos_y = y;
		item.texture_id = tex;
		item.tile_kind = kind;
		send_req(item);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed_edges();
		send_tile(MODE_ERASE, 2'd0, 16'h0000, 16'h0000, 10'd0, 3'd0);
		send_tile(MODE_PLACE, 2'd0, 16'h8000, 16'h7fff, 10'd1023, 3'd4);
		send_tile(MODE_PLACE, 2'd0, 16'h7fff, 16'h8000, 10'd0, 3'd0);
		send_tile(MODE_PLACE, 2'd0, 16'h0000, 16'h0000, 10'd5, 3'd7);
		send_tile(MODE_PLACE, 2'd0, 16'hffff, 16'hffff, 10'd512, 3'd5);
		// differs from the zero key only in the sign bit of x
		send_tile(MODE_PLACE, 2'd0, 16'h8000, 16'h0000, 10'd341, 3'd6);
		send_tile(MODE_PLACE, 2'd0, 16'h8000, 16'h7fff, 10'd0, 3'd1);
		send_tile(MODE_PLACE, 2'd0, 16'hffff, 16'hffff, 10'd1023, 3'd3);
		send_tile(MODE_ERASE, 2'd0, 16'h7fff, 16'h8000, 10'd0, 3'd0);
		// key now at the tail: erase it so it moves onto itself
		send_tile(MODE_ERASE, 2'd0, 16'hffff, 16'hffff, 10'd0, 3'd0);
		send_tile(MODE_ERASE, 2'd0, 16'hffff, 16'hffff, 10'd0, 3'd0);
		send_tile(MODE_ERASE, 2'd0, 16'h8000, 16'h7fff, 10'd1023, 3'd7);
		send_tile(MODE_PLACE, 2'd1, 16'h0001, 16'h0002, 10'd682, 3'd2);
		send_tile(MODE_PLACE, 2'd2, 16'h0001, 16'h0002, 10'd21, 3'd3);
		send_tile(MODE_ERASE, 2'd1, 16'h0001, 16'h0002, 10'd0, 3'd0);
		send_tile(MODE_PLACE, 2'd2, 16'h0001, 16'h0002, 10'd1002, 3'd1);
		send_tile(MODE_ERASE, 2'd3, 16'h0001, 16'h0002, 10'd0, 3'd0);
		send_tile(MODE_PLACE, 2'd3, 16'h5555, 16'haaaa, 10'd0, 3'd2);
		send_tile(MODE_ERASE, 2'd3, 16'h5555, 16'haaaa, 10'd0, 3'd0);
		drain_results();
	endtask

	task automatic test_fill_and_full();
		tile_t last;
		for (int i = 0; i < SLOTS; i++)
			send_tile(MODE_PLACE, 2'd3, i[15:0], 16'($urandom), 10'($urandom_range(0, 1023)),
				3'($urandom_range(0, 7)));
		// x of 2000 lies outside the fill keys
		send_tile(MODE_PLACE, 2'd3, 16'd2000, 16'h1234, 10'd7, 3'd1);
		send_tile(MODE_ERASE, 2'd3, 16'd2000, 16'h1234, 10'd0, 3'd0);
		last = tile_mem[3][SLOTS-1];
		send_tile(MODE_PLACE, 2'd3, last.x, last.y, 10'd1023, 3'd7);
		send_tile(MODE_ERASE, 2'd3, last.x, last.y, 10'd0, 3'd0);
		send_tile(MODE_PLACE, 2'd3, 16'd2000, 16'h1234, 10'd7, 3'd1);
		last = tile_mem[3][0];
		send_tile(MODE_ERASE, 2'd3, last.x, last.y, 10'd0, 3'd0);
		send_tile(MODE_PLACE, 2'd3, 16'd2001, 16'hedcb, 10'd300, 3'd2);
		drain_results();
	endtask

	task automatic test_result_backpressure();
		idle_en = 1'b0;
		hold_cycles = 500;
		for (int i = 0; i < 16; i++)
			send_tile((i % 4 == 3) ? MODE_ERASE : MODE_PLACE, 2'd0, 16'($urandom_range(0, 7)),
				16'h0100, 10'($urandom_range(0, 1023)), 3'($urandom_range(0, 7)));
		idle_en = 1'b1;
		drain_results();
	endtask

	task automatic test_random_traffic();
		logic [15:0] pool_x [3][POOL_KEYS];
		logic [15:0] pool_y [3][POOL_KEYS];
		logic [1:0] l;
		logic [15:0] x;
		logic [15:0] y;
		int r;
		int idx;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < POOL_KEYS; j++) begin
				pool_x[i][j] = 16'($urandom);
				pool_y[i][j] = 16'($urandom);
			end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0)
				idle_en = ($urandom_range(0, 3) != 0);
			// the full layer costs a whole scan per beat, so visit it rarely
			l = ($urandom_range(0, 99) < 5) ? 2'd3 : 2'($urandom_range(0, 2));
			r = $urandom_range(0, 99);
			if (r < 45 && tile_count[l] > 0) begin
				idx = $urandom_range(0, tile_count[l] - 1);
				x = tile_mem[l][idx].x;
				y = tile_mem[l][idx].y;
			end else if (r < 85 && l != 2'd3) begin
				idx = $urandom_range(0, POOL_KEYS - 1);
				x = pool_x[l][idx];
				y = pool_y[l][idx];
			end else begin
				x = 16'($urandom);
				y = 16'($urandom);
			end
			send_tile(($urandom_range(0, 99) < 40) ? MODE_ERASE : MODE_PLACE, l, x, y,
				10'($urandom_range(0, 1023)), 3'($urandom_range(0, 7)));
		end
		idle_en = 1'b1;
		drain_results();
	endtask

	// result side stall: random idling plus a forced long hold on request
	initial begin
		int stall_left;
		stall_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				hold_cycles--;
			end else if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
				if (idle_en && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result beat with nothing pending", '0, rsp);
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status || rsp.slot !== want.slot ||
					rsp.count_after !== want.count_after)
					flag_mismatch("result beat mismatch", want, rsp);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		for (int i = 0; i < LAYERS; i++)
			tile_count[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_fill_and_full();
		test_result_backpressure();
		test_random_traffic();

		// watch for stray result beats
		repeat (SLOTS + 16) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
